@@ src/sme_pkg.sv @@
package sme_pkg;

	localparam int MAX_ITEMS_DEF = 32;
	localparam int MAX_SIZE_DEF  = 16;

	// Chain payload widths cover up to 64 cells (positions) and 64 items (values); the mask field holds only 32 items
	localparam int TOK_W = 8;
	localparam int POS_W = 6;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_COMMIT,
		ST_LAUNCH,
		ST_EMIT,
		ST_HOLD
	} state_t;

	typedef enum logic [1:0] {
		CMD_NONE,
		CMD_FILL,
		CMD_ADVANCE
	} cmd_t;

	// Token handed from cell to cell, one hop per cycle
	typedef struct packed {
		logic              vld;
		logic              emit;   // 0: carry search, 1: mask collection
		logic [TOK_W-1:0]  c;      // value a cell takes if the raised index is at or left of it
		logic [POS_W-1:0]  e;      // rightmost raisable position seen so far
		logic              found;
		logic [31:0]       mask;
		logic              any_r;
	} tok_t;

	// Limits broadcast to every cell
	typedef struct packed {
		logic [TOK_W-1:0] n;
		logic [TOK_W-1:0] k;
	} bcast_t;

	// Update command broadcast to every cell
	typedef struct packed {
		cmd_t             op;
		logic [POS_W-1:0] e;
	} commit_t;

endpackage

@@ src/subset_mask_enumerator_unit.sv @@
// Subset mask enumerator. Each input word asks for the next subset of the
// item_count items: all singletons first, then all pairs, and so on up to
// max_size (clamped to MAX_SIZE and to the item count), lexicographic within a size. A word
// with restart set (s_tdata bit 0), the word after the final subset, the first
// word after reset, and any word after max_size drops below the current size
// start over at the singleton {0}. Each result word carries the subset as a
// bit mask, its size, and m_tlast on the final subset of the largest size.
// The stored indices live in a row of MAX_SIZE cells; a token walks the row
// one cell per cycle, first to find the rightmost index that can rise and
// build the refill values, then, after the update in the commit state, to
// collect the mask. A word that starts over skips the first walk. The next
// word is accepted only once both walks are done and the result has gone to
// the output register. A finished result waits in the output register while
// the next word is accepted and worked on. Registers: item_count at byte
// address 0, max_size at byte address 4; the user must write them only while
// no word is in flight, which the block itself does not enforce.
module subset_mask_enumerator_unit #(
	parameter int MAX_ITEMS = sme_pkg::MAX_ITEMS_DEF,
	parameter int MAX_SIZE  = sme_pkg::MAX_SIZE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// request stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [0] restart, [7:1] zero
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [31:0] subset_mask, [36:32] subset_size, [39:37] zero
	output logic        m_tlast    // last_row
);

	localparam int IW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int SW = $clog2(MAX_SIZE + 1);
	localparam int TW = sme_pkg::TOK_W;

	// configuration registers
	logic [5:0] item_count_q;
	logic [4:0] max_size_q;

	// control state
	sme_pkg::state_t state_q;
	sme_pkg::state_t state_d;
	logic [SW-1:0]   size_q;

	// update decision for the commit cycle
	sme_pkg::cmd_t              cmd_q;
	logic [SW-1:0]              new_size_q;
	logic [sme_pkg::POS_W-1:0]  e_q;

	// result waiting for the output register
	logic [31:0] pend_mask_q;
	logic        pend_last_q;

	// output register
	logic        out_vld_q;
	logic [31:0] out_mask_q;
	logic [4:0]  out_size_q;
	logic        out_last_q;

	logic [TW-1:0]    n_eff;
	logic [TW-1:0]    m_lim;
	logic [TW-1:0]    m_clip;
	logic [TW-1:0]    m_eff;
	logic [TW-1:0]    size_ext;
	logic             accept;
	logic             start_over;
	logic             load_out;
	sme_pkg::bcast_t  lim;
	sme_pkg::commit_t cmt;
	sme_pkg::tok_t    tok_head;
	sme_pkg::tok_t    chain [MAX_SIZE+1];

	// APB: always ready, write on the access cycle
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_count_q <= 6'd32;
			max_size_q   <= 5'd1;
		end else if (psel && penable && pwrite) begin
			if (paddr[2]) begin
				max_size_q <= pwdata[4:0];
			end else begin
				item_count_q <= pwdata[5:0];
			end
		end
	end

	assign prdata = paddr[2] ? {27'd0, max_size_q} : {26'd0, item_count_q};

	// effective limits: zero counts as one, clamp to the build maxima and the size to the item count
	always_comb begin
		if (item_count_q == 6'd0) begin
			n_eff = TW'(1);
		end else if (TW'(item_count_q) > TW'(MAX_ITEMS)) begin
			n_eff = TW'(MAX_ITEMS);
		end else begin
			n_eff = TW'(item_count_q);
		end
		m_lim  = (max_size_q == 5'd0) ? TW'(1) : TW'(max_size_q);
		m_clip = (m_lim > TW'(MAX_SIZE)) ? TW'(MAX_SIZE) : m_lim;
		m_eff  = (m_clip > n_eff) ? n_eff : m_clip;
	end

	assign size_ext   = TW'(size_q);
	assign accept     = s_tvalid && s_tready;
	assign start_over = s_tdata[0] || (size_q == '0) || (size_ext > m_eff);

	assign lim.n = n_eff;
	assign lim.k = size_ext;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sme_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = start_over ? sme_pkg::ST_COMMIT : sme_pkg::ST_SEARCH;
				end
			end
			sme_pkg::ST_SEARCH: begin
				if (chain[MAX_SIZE].vld) begin
					state_d = sme_pkg::ST_COMMIT;
				end
			end
			sme_pkg::ST_COMMIT: begin
				state_d = sme_pkg::ST_LAUNCH;
			end
			sme_pkg::ST_LAUNCH: begin
				state_d = sme_pkg::ST_EMIT;
			end
			sme_pkg::ST_EMIT: begin
				if (chain[MAX_SIZE].vld) begin
					state_d = sme_pkg::ST_HOLD;
				end
			end
			sme_pkg::ST_HOLD: begin
				if (!out_vld_q || m_tready) begin
					state_d = sme_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sme_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sme_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// state outputs: ready, token launch, commit broadcast, output load
	always_comb begin
		s_tready = 1'b0;
		tok_head = '0;
		cmt.op   = sme_pkg::CMD_NONE;
		cmt.e    = e_q;
		load_out = 1'b0;
		unique case (state_q)
			sme_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				// launch the search token in the same cycle the word is taken
				tok_head.vld = accept && !start_over;
			end
			sme_pkg::ST_COMMIT: begin
				cmt.op = cmd_q;
			end
			sme_pkg::ST_LAUNCH: begin
				tok_head.vld  = 1'b1;
				tok_head.emit = 1'b1;
			end
			sme_pkg::ST_HOLD: begin
				load_out = !out_vld_q || m_tready;
			end
			default: begin
			end
		endcase
	end

	assign chain[0] = tok_head;

	// row of index cells
	for (genvar gi = 0; gi < MAX_SIZE; gi++) begin : g_cell
		sme_cell #(
			.POS (gi),
			.IW  (IW)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.lim     (lim),
			.cmt     (cmt),
			.tok_in  (chain[gi]),
			.tok_out (chain[gi+1])
		);
	end

	// current size is updated on the commit cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= '0;
		end else if (state_q == sme_pkg::ST_COMMIT) begin
			size_q <= new_size_q;
		end
	end

	// pick the update: start over, raise and refill, or grow the size
	always_ff @(posedge clk) begin
		if (state_q == sme_pkg::ST_IDLE && accept && start_over) begin
			cmd_q      <= sme_pkg::CMD_FILL;
			new_size_q <= SW'(1);
		end else if (state_q == sme_pkg::ST_SEARCH && chain[MAX_SIZE].vld) begin
			if (chain[MAX_SIZE].found) begin
				cmd_q      <= sme_pkg::CMD_ADVANCE;
				e_q        <= chain[MAX_SIZE].e;
				new_size_q <= size_q;
			end else if (size_ext + TW'(1) <= m_eff) begin
				cmd_q      <= sme_pkg::CMD_FILL;
				new_size_q <= size_q + SW'(1);
			end else begin
				cmd_q      <= sme_pkg::CMD_FILL;
				new_size_q <= SW'(1);
			end
		end
	end

	// capture the collected mask; final subset when no index can rise at full size
	always_ff @(posedge clk) begin
		if (state_q == sme_pkg::ST_EMIT && chain[MAX_SIZE].vld) begin
			pend_mask_q <= chain[MAX_SIZE].mask;
			pend_last_q <= (size_ext == m_eff) && !chain[MAX_SIZE].any_r;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (load_out) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_mask_q <= pend_mask_q;
			out_size_q <= 5'(size_q);
			out_last_q <= pend_last_q;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {3'd0, out_size_q, out_mask_q};
	assign m_tlast  = out_last_q;

endmodule

@@ src/sme_cell.sv @@
module sme_cell #(
	parameter int POS = 0,
	parameter int IW  = 5
) (
	input  logic            clk,
	input  logic            arst_n,
	input  sme_pkg::bcast_t lim,
	input  sme_pkg::commit_t cmt,
	input  sme_pkg::tok_t   tok_in,
	output sme_pkg::tok_t   tok_out
);

	localparam logic [sme_pkg::TOK_W-1:0] POS_T = sme_pkg::TOK_W'(POS);
	localparam logic [sme_pkg::POS_W-1:0] POS_P = sme_pkg::POS_W'(POS);

	logic [IW-1:0]            idx_q;
	logic [IW-1:0]            tent_q;
	logic [sme_pkg::TOK_W-1:0] idx_ext;
	logic [sme_pkg::TOK_W-1:0] bound;
	logic                     active;
	logic                     raisable;
	logic [63:0]              wide_bit;
	sme_pkg::tok_t            tok_d;
	sme_pkg::tok_t            tok_q;

	assign idx_ext  = sme_pkg::TOK_W'(idx_q);
	assign active   = POS_T < lim.k;
	assign bound    = lim.n - lim.k + POS_T;
	assign raisable = active && (idx_ext < bound);
	assign wide_bit = 64'd1 << idx_q;

	always_comb begin
		tok_d = tok_in;
		if (tok_in.vld && active) begin
			if (tok_in.emit) begin
				tok_d.mask  = tok_in.mask | wide_bit[31:0];
				tok_d.any_r = tok_in.any_r | raisable;
			end else if (raisable) begin
				tok_d.c     = idx_ext + sme_pkg::TOK_W'(1);
				tok_d.e     = POS_P;
				tok_d.found = 1'b1;
			end else begin
				tok_d.c     = tok_in.c + sme_pkg::TOK_W'(1);
			end
		end
	end

	// hand the token to the right neighbor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_d;
		end
	end

	// hold the tentative value from the search pass
	always_ff @(posedge clk) begin
		if (tok_in.vld && !tok_in.emit && active) begin
			tent_q <= tok_d.c[IW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmt.op)
			sme_pkg::CMD_FILL: begin
				idx_q <= IW'(POS);
			end
			sme_pkg::CMD_ADVANCE: begin
				if (active && (POS_P >= cmt.e)) begin
					idx_q <= tent_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign tok_out = tok_q;

endmodule

@@ src/sme_checker.sv @@
module sme_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic        m_tlast
);

	// stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result word changed under stall");

	// every emitted subset states a size of at least one
	a_size: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[36:32] != 5'd0)
		else $error("empty subset emitted");

	// never more mask bits than the stated size
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $countones(m_tdata[31:0]) <= m_tdata[36:32])
		else $error("mask has more bits than subset size");

	// a singleton shows at most one bit
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[36:32] == 5'd1 |-> $onehot0(m_tdata[31:0]))
		else $error("singleton mask has several bits");

endmodule

bind subset_mask_enumerator_unit sme_checker u_sme_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
